// ===== hdl/mts_pkg.sv =====
package mts_pkg;

  localparam int unsigned SlotsDef = 16;
  localparam int unsigned IdxW     = 8;   // covers up to 256 slots
  localparam int unsigned CntW     = 9;   // holds 0..256
  localparam logic [28:0] DivMagic = 29'h10624DD3;  // x/1000 = (x*DivMagic) >> 38
  localparam int unsigned DivShift = 38;

  localparam logic [3:0] OP_TICK     = 4'd0;
  localparam logic [3:0] OP_ADD_OS   = 4'd1;
  localparam logic [3:0] OP_ADD_PER  = 4'd2;
  localparam logic [3:0] OP_ADD_CD   = 4'd3;
  localparam logic [3:0] OP_CLEAR    = 4'd4;
  localparam logic [3:0] OP_CLR_OS   = 4'd5;
  localparam logic [3:0] OP_CLR_PER  = 4'd6;
  localparam logic [3:0] OP_CLR_CD   = 4'd7;
  localparam logic [3:0] OP_PAUSE    = 4'd8;
  localparam logic [3:0] OP_RESUME   = 4'd9;
  localparam logic [3:0] OP_RESTART  = 4'd10;
  localparam logic [3:0] OP_QUERY    = 4'd11;

  localparam logic [1:0] KIND_OS  = 2'd0;
  localparam logic [1:0] KIND_PER = 2'd1;
  localparam logic [1:0] KIND_CD  = 2'd2;

  localparam logic [1:0] EV_RESP  = 2'd0;
  localparam logic [1:0] EV_FIRED = 2'd1;
  localparam logic [1:0] EV_TICK  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_INVALID  = 2'd1;
  localparam logic [1:0] STAT_BUSY     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  localparam logic [1:0] TST_RUNNING  = 2'd0;
  localparam logic [1:0] TST_PAUSED   = 2'd1;
  localparam logic [1:0] TST_NOTFOUND = 2'd2;

  localparam logic [1:0] REG_MAX_OS  = 2'd0;
  localparam logic [1:0] REG_MAX_PER = 2'd1;
  localparam logic [1:0] REG_MAX_CD  = 2'd2;

  typedef enum logic [1:0] {
    SRCH_MIN  = 2'd0,
    SRCH_FIND = 2'd1,
    SRCH_FREE = 2'd2
  } search_e;

  typedef struct packed {
    logic [3:0]  op;
    logic [15:0] timer_id;
    logic [31:0] amount_ms;
    logic [31:0] step_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [1:0]  timer_kind;
    logic [1:0]  timer_state;
    logic [31:0] elapsed_ms;
    logic [31:0] remaining_ms;
    logic [22:0] elapsed_s;
    logic [22:0] remaining_s;
    logic        finished;
    logic        late;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic        done;
    logic [1:0]  kind;
    logic        paused;
    logic [15:0] ident;
    logic [31:0] period;
    logic [31:0] step;
    logic [31:0] elapsed;
    logic [31:0] held;
    logic [63:0] due;
  } slot_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
    logic [CntW-1:0] cnt;
    slot_t           rec;
  } cand_t;

  typedef struct packed {
    search_e     mode;
    logic [63:0] now;
    logic [15:0] id;
    logic [1:0]  kind;
    logic        clr_done;
  } scan_key_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    slot_t           rec;
  } slot_wr_t;

  typedef struct packed {
    logic [4:0] max_os;
    logic [4:0] max_per;
    logic [4:0] max_cd;
  } limits_t;

endpackage

// ===== hdl/mts_cell.sv =====
module mts_cell import mts_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_key_t key_i,
  input  slot_wr_t  wr_i,
  input  cand_t     cand_i,
  output cand_t     cand_o
);

  logic  valid_q, done_q;
  slot_t rec_q;
  slot_t mine;
  logic  take;
  logic  hit;
  cand_t cand_d, cand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else if (wr_i.en && wr_i.idx == IdxW'(INDEX)) begin
      valid_q <= wr_i.rec.valid;
      done_q  <= wr_i.rec.done;
    end else if (key_i.clr_done) begin
      done_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.idx == IdxW'(INDEX)) begin
      rec_q <= wr_i.rec;
    end
  end

  always_comb begin
    mine       = rec_q;
    mine.valid = valid_q;
    mine.done  = done_q;
    take       = 1'b0;
    hit        = 1'b0;
    case (key_i.mode)
      SRCH_MIN: begin
        if (valid_q && !rec_q.paused && !done_q && rec_q.due <= key_i.now) begin
          take = !cand_i.found || rec_q.due < cand_i.rec.due ||
                 (rec_q.due == cand_i.rec.due && rec_q.ident < cand_i.rec.ident);
        end
      end
      SRCH_FIND: take = valid_q && rec_q.ident == key_i.id && !cand_i.found;
      SRCH_FREE: begin
        take = !valid_q && !cand_i.found;
        hit  = valid_q && rec_q.kind == key_i.kind;
      end
      default: take = 1'b0;
    endcase
    cand_d     = cand_i;
    cand_d.cnt = cand_i.cnt + CntW'(hit);
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.idx   = IdxW'(INDEX);
      cand_d.rec   = mine;
    end
  end

  // scan data moves one cell per cycle
  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  assign cand_o = cand_q;

endmodule

// ===== hdl/mts_ctrl.sv =====
module mts_ctrl import mts_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  limits_t   limits_i,
  input  cand_t     res_i,
  output scan_key_t key_o,
  output slot_wr_t  wr_o
);

  localparam int unsigned ScW = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_CALC   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  state_e    state_q, state_d;
  in_item_t  item_q;
  logic [63:0] now_q;
  logic [15:0] next_id_q, next_id_d;
  logic [ScW-1:0] sc_q;
  logic [31:0] el2_q;
  out_item_t out_q, out_d;
  slot_wr_t  wr_q, wr_d;
  logic      accept;
  logic [1:0] add_kind;
  logic [4:0] lim;
  slot_t     rec;
  logic [31:0] left, adv, rem, nstep;
  logic [63:0] gap;
  logic [60:0] prod_e, prod_r;

  assign accept      = in_valid_i && state_q == ST_IDLE;
  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = state_q == ST_OUT;
  assign out_data_o  = out_q;
  assign wr_o        = wr_q;
  assign add_kind    = 2'(item_q.op - OP_ADD_OS);
  assign rec         = res_i.rec;

  always_comb begin
    key_o          = '0;
    key_o.now      = now_q;
    key_o.id       = item_q.timer_id;
    key_o.kind     = add_kind;
    key_o.clr_done = accept && in_data_i.op == OP_TICK;
    if (item_q.op == OP_TICK) begin
      key_o.mode = SRCH_MIN;
    end else if (item_q.op <= OP_ADD_CD) begin
      key_o.mode = SRCH_FREE;
    end else begin
      key_o.mode = SRCH_FIND;
    end
  end

  always_comb begin
    unique case (add_kind)
      KIND_OS:  lim = limits_i.max_os;
      KIND_PER: lim = limits_i.max_per;
      default:  lim = limits_i.max_cd;
    endcase
  end

  always_comb begin
    left = rec.period > rec.elapsed ? rec.period - rec.elapsed : 32'd0;
    adv  = rec.step < left ? rec.step : left;
    rem  = rec.period > el2_q ? rec.period - el2_q : 32'd0;
    nstep = rec.step < rem ? rec.step : rem;
    gap  = rec.due > now_q ? rec.due - now_q : 64'd1;
  end

  always_comb begin
    out_d      = '0;
    out_d.last = 1'b1;
    wr_d       = '0;
    wr_d.idx   = res_i.idx;
    wr_d.rec   = rec;
    next_id_d  = next_id_q;
    if (item_q.op == OP_TICK) begin
      if (!res_i.found) begin
        out_d.event_res = EV_TICK;
      end else begin
        out_d.event_res  = EV_FIRED;
        out_d.last       = 1'b0;
        out_d.result_id  = rec.ident;
        out_d.timer_kind = rec.kind;
        out_d.late       = now_q > rec.due;
        wr_d.en          = 1'b1;
        wr_d.rec.done    = 1'b1;
        if (rec.kind == KIND_OS) begin
          wr_d.rec.valid = 1'b0;
        end else if (rec.kind == KIND_PER) begin
          wr_d.rec.due = now_q + 64'(rec.period);
        end else begin
          wr_d.rec.elapsed   = el2_q;
          out_d.elapsed_ms   = el2_q;
          out_d.remaining_ms = rem;
          out_d.finished     = el2_q >= rec.period;
          if (el2_q >= rec.period) begin
            wr_d.rec.valid = 1'b0;
          end else begin
            wr_d.rec.due = now_q + 64'(nstep);
          end
        end
      end
    end else if (item_q.op <= OP_ADD_CD) begin
      out_d.timer_kind = add_kind;
      if (item_q.amount_ms == 32'd0 || (add_kind == KIND_CD &&
          (item_q.step_ms == 32'd0 || item_q.step_ms > item_q.amount_ms))) begin
        out_d.status = STAT_INVALID;
      end else if (res_i.cnt >= CntW'(lim) || !res_i.found) begin
        out_d.status = STAT_BUSY;
      end else begin
        out_d.result_id     = next_id_q;
        next_id_d           = next_id_q == 16'hFFFF ? 16'd1 : next_id_q + 16'd1;
        wr_d.en             = 1'b1;
        wr_d.rec.valid      = 1'b1;
        wr_d.rec.done       = 1'b0;
        wr_d.rec.kind       = add_kind;
        wr_d.rec.paused     = 1'b0;
        wr_d.rec.ident      = next_id_q;
        wr_d.rec.period     = item_q.amount_ms;
        wr_d.rec.step       = add_kind == KIND_CD ? item_q.step_ms : 32'd0;
        wr_d.rec.elapsed    = 32'd0;
        wr_d.rec.held       = 32'd0;
        wr_d.rec.due        = now_q + 64'(add_kind == KIND_CD ? item_q.step_ms
                                                              : item_q.amount_ms);
      end
    end else if (item_q.op > OP_QUERY) begin
      out_d.status = STAT_INVALID;
    end else if (!res_i.found) begin
      out_d.status      = STAT_NOTFOUND;
      out_d.timer_state = item_q.op == OP_QUERY ? TST_NOTFOUND : TST_RUNNING;
    end else begin
      out_d.result_id  = item_q.timer_id;
      out_d.timer_kind = rec.kind;
      unique case (item_q.op)
        OP_CLEAR: begin
          wr_d.en        = 1'b1;
          wr_d.rec.valid = 1'b0;
        end
        OP_CLR_OS, OP_CLR_PER, OP_CLR_CD: begin
          if (rec.kind != 2'(item_q.op - OP_CLR_OS)) begin
            out_d.status = STAT_INVALID;
          end else begin
            wr_d.en        = 1'b1;
            wr_d.rec.valid = 1'b0;
          end
        end
        OP_PAUSE: begin
          if (!rec.paused) begin
            wr_d.en         = 1'b1;
            wr_d.rec.paused = 1'b1;
            wr_d.rec.held   = gap[63:32] != 32'd0 ? 32'hFFFF_FFFF : gap[31:0];
          end
        end
        OP_RESUME: begin
          if (rec.paused) begin
            wr_d.en         = 1'b1;
            wr_d.rec.paused = 1'b0;
            wr_d.rec.held   = 32'd0;
            wr_d.rec.due    = now_q + 64'(rec.held != 32'd0 ? rec.held : 32'd1);
          end
        end
        OP_RESTART: begin
          wr_d.en         = 1'b1;
          wr_d.rec.paused = 1'b0;
          wr_d.rec.held   = 32'd0;
          if (rec.kind == KIND_CD) begin
            wr_d.rec.elapsed = 32'd0;
            wr_d.rec.due     = now_q + 64'(rec.step);
          end else begin
            wr_d.rec.due = now_q + 64'(rec.period);
          end
        end
        default: out_d.timer_state = rec.paused ? TST_PAUSED : TST_RUNNING;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (sc_q == ScW'(SLOTS - 1)) state_d = ST_CALC;
      ST_CALC:   state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_DIV;
      ST_DIV:    state_d = ST_OUT;
      ST_OUT: begin
        if (!out_stall_i) state_d = out_q.last ? ST_IDLE : ST_SCAN;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      now_q     <= 64'd0;
      next_id_q <= 16'd1;
      sc_q      <= '0;
      wr_q      <= '0;
    end else begin
      state_q <= state_d;
      wr_q.en <= 1'b0;
      if (accept && in_data_i.op == OP_TICK) begin
        now_q <= now_q + 64'(in_data_i.amount_ms);
      end
      if (state_q == ST_SCAN) begin
        sc_q <= sc_q + ScW'(1);
      end else begin
        sc_q <= '0;
      end
      if (state_q == ST_DECIDE) begin
        wr_q      <= wr_d;
        next_id_q <= next_id_d;
      end
    end
  end

  assign prod_e = 61'(out_q.elapsed_ms) * 61'(DivMagic);
  assign prod_r = 61'(out_q.remaining_ms) * 61'(DivMagic);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_CALC) begin
      el2_q <= rec.elapsed + adv;
    end
    if (state_q == ST_DECIDE) begin
      out_q <= out_d;
    end
    if (state_q == ST_DIV) begin
      out_q.elapsed_s   <= prod_e[60:DivShift];
      out_q.remaining_s <= prod_r[60:DivShift];
    end
  end

`ifndef NO_ASSERTIONS
  a_wr_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q.en |-> state_q == ST_DIV)
    else $error("slot write outside write-back cycle");
  a_fire_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_q.event_res == EV_FIRED |-> !out_q.last)
    else $error("firing marked last");
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_SCAN && sc_q == '0)
    else $error("transfer did not start a scan");
`endif

endmodule

// ===== hdl/multi_timer_scheduler_top.sv =====
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
// out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
// cfg     | input     | APB psel/penable/pwrite   | paddr, pwdata, prdata
//
// Output stall time adds to the time a command takes. A tick that fires
// timers handles one firing at a time: each firing re-runs the
// scan down the chain of SLOTS cells, one cell per cycle, then write-back.
// Reset clears slot valid bits and the clock and sets limits to 16 at once; no clearing pass.
// The input is stalled from a transfer until its last result has been taken.
module multi_timer_scheduler_top import mts_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  limits_t   lim_q;
  scan_key_t key;
  slot_wr_t  wr;
  cand_t     chain [SLOTS+1];

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.max_os  <= 5'd16;
      lim_q.max_per <= 5'd16;
      lim_q.max_cd  <= 5'd16;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MAX_OS:  lim_q.max_os  <= pwdata[4:0];
        REG_MAX_PER: lim_q.max_per <= pwdata[4:0];
        REG_MAX_CD:  lim_q.max_cd  <= pwdata[4:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_OS:  prdata = 32'(lim_q.max_os);
      REG_MAX_PER: prdata = 32'(lim_q.max_per);
      REG_MAX_CD:  prdata = 32'(lim_q.max_cd);
      default:     prdata = 32'd0;
    endcase
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    mts_cell #(.INDEX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key),
      .wr_i   (wr),
      .cand_i (chain[g]),
      .cand_o (chain[g+1])
    );
  end

  mts_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .limits_i    (lim_q),
    .res_i       (chain[SLOTS]),
    .key_o       (key),
    .wr_o        (wr)
  );

endmodule

// ===== bench/tb_multi_timer_scheduler_top.sv =====
module tb_multi_timer_scheduler_top import mts_pkg::*;;

  localparam int unsigned NSLOT = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  multi_timer_scheduler_top dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // shadow timer table
  bit          tm_valid [NSLOT];
  bit          tm_paused[NSLOT];
  logic [1:0]  tm_kind  [NSLOT];
  logic [15:0] tm_ident [NSLOT];
  logic [31:0] tm_period[NSLOT];
  logic [31:0] tm_step  [NSLOT];
  logic [31:0] tm_elap  [NSLOT];
  logic [31:0] tm_held  [NSLOT];
  logic [63:0] tm_due   [NSLOT];
  logic [63:0] clock_ms = '0;
  logic [15:0] next_ident = 16'd1;
  logic [4:0]  kind_limit[3] = '{5'd16, 5'd16, 5'd16};

  out_item_t   pending_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;

  function automatic out_item_t mk_res(logic [1:0] ev, logic [1:0] st, logic [15:0] id,
                                       logic [1:0] kind, logic [1:0] tst, logic [31:0] el,
                                       logic [31:0] rem, logic fin, logic late, logic lst);
    out_item_t r;
    r.event_res = ev;
    r.status = st;
    r.result_id = id;
    r.timer_kind = kind;
    r.timer_state = tst;
    r.elapsed_ms = el;
    r.remaining_ms = rem;
    r.elapsed_s = 23'(el / 1000);
    r.remaining_s = 23'(rem / 1000);
    r.finished = fin;
    r.late = late;
    r.last = lst;
    return r;
  endfunction

  function automatic out_item_t resp(logic [1:0] st, logic [15:0] id, logic [1:0] kind,
                                     logic [1:0] tst);
    return mk_res(EV_RESP, st, id, kind, tst, '0, '0, 1'b0, 1'b0, 1'b1);
  endfunction

  task automatic expect_res(out_item_t r);
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic run_tick(logic [31:0] amt);
    bit done[NSLOT];
    int b;
    logic [31:0] el, rem, left, s;
    logic fin, late;
    done = '{default: 1'b0};
    clock_ms += amt;
    forever begin
      b = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (!tm_valid[i] || tm_paused[i] || done[i] || tm_due[i] > clock_ms) continue;
        if (b < 0 || tm_due[i] < tm_due[b] ||
            (tm_due[i] == tm_due[b] && tm_ident[i] < tm_ident[b])) b = i;
      end
      if (b < 0) break;
      done[b] = 1'b1;
      late = clock_ms > tm_due[b];
      el = '0; rem = '0; fin = 1'b0;
      if (tm_kind[b] == KIND_OS) begin
        tm_valid[b] = 1'b0;
      end else if (tm_kind[b] == KIND_PER) begin
        tm_due[b] = clock_ms + tm_period[b];
      end else begin
        left = tm_period[b] > tm_elap[b] ? tm_period[b] - tm_elap[b] : '0;
        s = tm_step[b] < left ? tm_step[b] : left;
        tm_elap[b] += s;
        el = tm_elap[b];
        rem = tm_period[b] > el ? tm_period[b] - el : '0;
        fin = el >= tm_period[b];
        if (fin) tm_valid[b] = 1'b0;
        else tm_due[b] = clock_ms + (tm_step[b] < rem ? tm_step[b] : rem);
      end
      expect_res(mk_res(EV_FIRED, STAT_OK, tm_ident[b], tm_kind[b], TST_RUNNING,
                        el, rem, fin, late, 1'b0));
    end
    expect_res(mk_res(EV_TICK, STAT_OK, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic run_add(logic [1:0] kind, logic [31:0] amt, logic [31:0] stp);
    int free_slot;
    int unsigned cnt;
    free_slot = -1;
    cnt = 0;
    if (amt == 0 || (kind == KIND_CD && (stp == 0 || stp > amt))) begin
      expect_res(resp(STAT_INVALID, '0, kind, TST_RUNNING));
      return;
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (tm_valid[i]) begin
        if (tm_kind[i] == kind) cnt++;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (cnt >= kind_limit[kind] || free_slot < 0) begin
      expect_res(resp(STAT_BUSY, '0, kind, TST_RUNNING));
      return;
    end
    tm_valid[free_slot] = 1'b1;
    tm_kind[free_slot] = kind;
    tm_paused[free_slot] = 1'b0;
    tm_ident[free_slot] = next_ident;
    tm_period[free_slot] = amt;
    tm_step[free_slot] = kind == KIND_CD ? stp : '0;
    tm_elap[free_slot] = '0;
    tm_held[free_slot] = '0;
    tm_due[free_slot] = clock_ms + (kind == KIND_CD ? stp : amt);
    next_ident = next_ident == 16'hFFFF ? 16'd1 : next_ident + 16'd1;
    expect_res(resp(STAT_OK, tm_ident[free_slot], kind, TST_RUNNING));
  endtask

  task automatic predict_item(in_item_t it);
    int s;
    logic [1:0] st, tst;
    logic [63:0] d;
    s = -1;
    st = STAT_OK;
    tst = TST_RUNNING;
    if (it.op == OP_TICK) begin
      run_tick(it.amount_ms);
      return;
    end
    if (it.op <= OP_ADD_CD) begin
      run_add(2'(it.op - OP_ADD_OS), it.amount_ms, it.step_ms);
      return;
    end
    if (it.op > OP_QUERY) begin
      expect_res(resp(STAT_INVALID, '0, '0, TST_RUNNING));
      return;
    end
    for (int i = NSLOT - 1; i >= 0; i--)
      if (tm_valid[i] && tm_ident[i] == it.timer_id) s = i;
    if (s < 0) begin
      expect_res(resp(STAT_NOTFOUND, '0, '0,
                      it.op == OP_QUERY ? TST_NOTFOUND : TST_RUNNING));
      return;
    end
    case (it.op)
      OP_CLEAR: tm_valid[s] = 1'b0;
      OP_CLR_OS, OP_CLR_PER, OP_CLR_CD: begin
        if (tm_kind[s] != 2'(it.op - OP_CLR_OS)) st = STAT_INVALID;
        else tm_valid[s] = 1'b0;
      end
      OP_PAUSE: begin
        if (!tm_paused[s]) begin
          d = tm_due[s] > clock_ms ? tm_due[s] - clock_ms : 64'd1;
          tm_held[s] = d > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : d[31:0];
          tm_paused[s] = 1'b1;
        end
      end
      OP_RESUME: begin
        if (tm_paused[s]) begin
          tm_due[s] = clock_ms + (tm_held[s] > 0 ? tm_held[s] : 32'd1);
          tm_held[s] = '0;
          tm_paused[s] = 1'b0;
        end
      end
      OP_RESTART: begin
        tm_paused[s] = 1'b0;
        tm_held[s] = '0;
        if (tm_kind[s] == KIND_CD) begin
          tm_elap[s] = '0;
          tm_due[s] = clock_ms + tm_step[s];
        end else begin
          tm_due[s] = clock_ms + tm_period[s];
        end
      end
      default: tst = tm_paused[s] ? TST_PAUSED : TST_RUNNING;
    endcase
    expect_res(resp(st, it.timer_id, tm_kind[s], tst));
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 99) < 20);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        if (out_data_o !== pending_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h got %h", pending_q[0], out_data_o);
        end
        void'(pending_q.pop_front());
      end
    end
  end

  function automatic in_item_t mk_in(logic [3:0] op, logic [15:0] id, logic [31:0] amt,
                                     logic [31:0] stp);
    in_item_t it;
    it.op = op;
    it.timer_id = id;
    it.amount_ms = amt;
    it.step_ms = stp;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int unsigned r;
    logic [31:0] amt;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      amt = $urandom_range(0, 99) < 92 ? $urandom_range(0, 12) : $urandom;
      return mk_in(OP_TICK, 16'($urandom), amt, $urandom);
    end
    if (r < 58) begin
      r = $urandom_range(0, 99);
      amt = r < 5 ? 32'd0 : (r < 10 ? $urandom : $urandom_range(1, 25));
      r = $urandom_range(0, 99);
      return mk_in(4'($urandom_range(OP_ADD_OS, OP_ADD_CD)), 16'($urandom), amt,
                   r < 4 ? 32'd0 : (r < 8 ? amt + 1 : (r < 12 ? $urandom :
                   $urandom_range(1, amt > 8 || amt == 0 ? 8 : amt))));
    end
    if (r < 96)
      return mk_in(4'($urandom_range(OP_CLEAR, OP_QUERY)),
                   $urandom_range(0, 99) < 85 ? next_ident - 16'($urandom_range(1, 18))
                                              : 16'($urandom),
                   $urandom, $urandom);
    return mk_in(4'($urandom_range(12, 15)), 16'($urandom), $urandom, $urandom);
  endfunction

  task automatic send(in_item_t it);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [4:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx) << 2;
    pwdata <= {27'($urandom), val} & 32'h1F;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    kind_limit[idx] = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limits(logic [4:0] os, logic [4:0] per, logic [4:0] cd);
    drain();
    write_limit(REG_MAX_OS, os);
    write_limit(REG_MAX_PER, per);
    write_limit(REG_MAX_CD, cd);
  endtask

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    in_item_t it;
    dir_rows = '{
      '{mk_in(OP_ADD_OS, 0, 0, 0), 1, resp(STAT_INVALID, 0, KIND_OS, TST_RUNNING)},
      '{mk_in(OP_ADD_CD, 0, 10, 0), 1, resp(STAT_INVALID, 0, KIND_CD, TST_RUNNING)},
      '{mk_in(OP_ADD_CD, 0, 10, 11), 1, resp(STAT_INVALID, 0, KIND_CD, TST_RUNNING)},
      '{mk_in(4'd12, 16'hFFFF, '1, '1), 1, resp(STAT_INVALID, 0, KIND_OS, TST_RUNNING)},
      '{mk_in(4'd15, 0, 0, 0), 1, resp(STAT_INVALID, 0, KIND_OS, TST_RUNNING)},
      '{mk_in(OP_QUERY, 16'h1234, 0, 0), 1, resp(STAT_NOTFOUND, 0, KIND_OS, TST_NOTFOUND)},
      '{mk_in(OP_ADD_OS, 0, 5, 0), 1, resp(STAT_OK, 1, KIND_OS, TST_RUNNING)},
      '{mk_in(OP_ADD_PER, 0, 3, 0), 1, resp(STAT_OK, 2, KIND_PER, TST_RUNNING)},
      '{mk_in(OP_ADD_CD, 0, 10, 4), 1, resp(STAT_OK, 3, KIND_CD, TST_RUNNING)},
      '{mk_in(OP_ADD_OS, 0, '1, '1), 1, resp(STAT_OK, 4, KIND_OS, TST_RUNNING)},
      '{mk_in(OP_ADD_CD, 0, '1, '1), 1, resp(STAT_OK, 5, KIND_CD, TST_RUNNING)},
      '{mk_in(OP_PAUSE, 2, 0, 0), 0, '0},
      '{mk_in(OP_PAUSE, 2, 0, 0), 0, '0},
      '{mk_in(OP_QUERY, 2, 0, 0), 1, resp(STAT_OK, 2, KIND_PER, TST_PAUSED)},
      '{mk_in(OP_TICK, 0, 3, 0), 0, '0},
      '{mk_in(OP_RESUME, 2, 0, 0), 0, '0},
      '{mk_in(OP_RESUME, 2, 0, 0), 0, '0},
      '{mk_in(OP_CLR_OS, 2, 0, 0), 1, resp(STAT_INVALID, 2, KIND_PER, TST_RUNNING)},
      '{mk_in(OP_TICK, 0, 10, 0), 0, '0},
      '{mk_in(OP_RESTART, 3, 0, 0), 0, '0},
      '{mk_in(OP_TICK, 0, 4, 0), 0, '0},
      '{mk_in(OP_CLEAR, 4, 0, 0), 1, resp(STAT_OK, 4, KIND_OS, TST_RUNNING)},
      '{mk_in(OP_CLEAR, 4, 0, 0), 1, resp(STAT_NOTFOUND, 0, KIND_OS, TST_RUNNING)},
      '{mk_in(OP_CLR_CD, 5, 0, 0), 1, resp(STAT_OK, 5, KIND_CD, TST_RUNNING)},
      '{mk_in(OP_TICK, 0, '1, 0), 0, '0}
    };
    for (int i = 0; i < NSLOT; i++) tm_valid[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      send(dir_rows[i].stim);
      if (dir_rows[i].typed) begin
        pending_q[pending_q.size() - 1] = dir_rows[i].want;
      end
    end
    // busy on zero limits, then small limits, full table, then random limits
    set_limits(5'd0, 5'd0, 5'd0);
    for (int k = OP_ADD_OS; k <= OP_ADD_CD; k++) send(mk_in(4'(k), 0, 7, 3));
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_limits(5'd1, 5'd2, 5'd3);
        1: set_limits(5'd16, 5'd16, 5'd16);
        default: set_limits(5'($urandom_range(0, 16)), 5'($urandom_range(0, 16)),
                            5'($urandom_range(0, 16)));
      endcase
      quiet = ph == 2;
      for (int n = 0; n < 25; n++) begin
        it = rand_item();
        if (ph == 1 && n < 18) it = mk_in(4'($urandom_range(OP_ADD_OS, OP_ADD_CD)), 0,
                                          $urandom_range(20, 60), $urandom_range(1, 5));
        send(it);
      end
      quiet = 1'b0;
    end
    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
